/* rtl/bslc_pkg.sv */
// Package: payload types, register indexes and state codes of the button press classifier
`timescale 1ns / 1ps
package bslc_pkg;

   // Input item
   typedef struct packed {
      logic [1:0] opcode;
      logic       button;
      logic       up_released;
      logic       down_released;
   } req_type;

   // Result item
   typedef struct packed {
      logic event_taken;
      logic held;
   } rsp_type;

   // Effective (limited) thresholds handed to each button
   typedef struct packed {
      logic [5:0] min_ticks;
      logic [6:0] long_ticks;
      logic [5:0] holdoff_ticks;
   } cfg_type;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 7;

   localparam logic [CSR_IDX_W-1:0] CSR_MIN_PRESS  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LONG_PRESS = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HOLDOFF    = 2'd2;

   localparam logic [5:0] MIN_PRESS_RESET  = 6'd2;
   localparam logic [6:0] LONG_PRESS_RESET = 7'd60;
   localparam logic [5:0] HOLDOFF_RESET    = 6'd10;

   localparam logic [6:0] LONG_PRESS_MAX = 7'd99;
   localparam logic [5:0] HOLDOFF_MAX    = 6'd49;

   localparam logic [1:0] OP_TICK       = 2'd0;
   localparam logic [1:0] OP_TAKE_SHORT = 2'd1;
   localparam logic [1:0] OP_TAKE_LONG  = 2'd2;
   localparam logic [1:0] OP_CLEAR      = 2'd3;

   localparam logic [7:0] CODE_IDLE     = 8'd0;
   localparam logic [7:0] CODE_HOLDOFF  = 8'd100;
   localparam logic [7:0] CODE_HOLD_END = 8'd150;
   localparam logic [7:0] CODE_EVENTS   = 8'd200;
   localparam logic [7:0] CODE_SHORT    = 8'd201;
   localparam logic [7:0] CODE_LONG     = 8'd202;
   localparam logic [7:0] CODE_TAKEN    = 8'd203;

endpackage

/* rtl/button_short_long_press_classifier_unit.sv */
// Top level: input register, two button state machines, result register, config registers
//
//   channel | direction | handshake          | payload
//   req     | in        | req_valid/req_stall | req_data  (opcode, button, pin levels)
//   rsp     | out       | rsp_valid/rsp_stall | rsp_data  (event_taken, held)
//   csr     | in        | csr_valid/csr_ready | csr_index, csr_data
//
// One item per cycle while the result is not stalled; a transferred item is held in the
// input register, moves into the result register when that register is free or draining,
// and transfers out from there, with the state update lying between the two registers.
// Reset clears both buttons to idle and loads the threshold defaults.
// A stalled result holds its register; the input register still takes one more item,
// then req_stall rises until the result drains.
`timescale 1ns / 1ps
module button_short_long_press_classifier_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  bslc_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output bslc_pkg::rsp_type                   rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [bslc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [bslc_pkg::CSR_DATA_W-1:0]     csr_data
);
   import bslc_pkg::*;

   logic       in_valid_ff;
   req_type    in_ff;
   logic       rsp_valid_ff;
   rsp_type    rsp_ff;
   rsp_type    rsp_in;
   logic       advance;
   logic       req_take;
   logic [1:0] hit;
   logic [1:0] released;
   logic       csr_write;
   logic [5:0] min_ff;
   logic [6:0] long_ff;
   logic [5:0] holdoff_ff;
   cfg_type    cfg;

   // advance: the buffered item moves into the result register
   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   assign released[0] = in_ff.up_released;
   assign released[1] = in_ff.down_released;

   // Limit thresholds to the ranges the code space allows
   assign cfg.long_ticks    = (long_ff > LONG_PRESS_MAX) ? LONG_PRESS_MAX : long_ff;
   assign cfg.min_ticks     = (min_ff == 6'd0) ? 6'd1 : min_ff;
   assign cfg.holdoff_ticks = (holdoff_ff > HOLDOFF_MAX) ? HOLDOFF_MAX : holdoff_ff;

   for (genvar b = 0; b < 2; b++) begin : g_button
      bslc_button u_button (
         .clock    (clock),
         .reset    (reset),
         .advance  (advance),
         .opcode   (in_ff.opcode),
         .selected (in_ff.button == 1'(b)),
         .released (released[b]),
         .cfg      (cfg),
         .hit      (hit[b])
      );
   end

   assign rsp_in.event_taken = |hit;
   assign rsp_in.held        = !released[in_ff.button];

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         min_ff       <= MIN_PRESS_RESET;
         long_ff      <= LONG_PRESS_RESET;
         holdoff_ff   <= HOLDOFF_RESET;
      end else begin
         if (req_take) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (csr_write) begin
            case (csr_index)
               CSR_MIN_PRESS:  min_ff     <= csr_data[5:0];
               CSR_LONG_PRESS: long_ff    <= csr_data;
               CSR_HOLDOFF:    holdoff_ff <= csr_data[5:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_ff <= req_data;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff && rsp_valid_ff && rsp_stall)
      else $error("input stalled without a blocked result");

   a_taken_op: assert property (@(posedge clock) disable iff (reset)
      advance && rsp_in.event_taken |->
         (in_ff.opcode == OP_TAKE_SHORT || in_ff.opcode == OP_TAKE_LONG))
      else $error("event reported for a tick or clear");

   a_one_hit: assert property (@(posedge clock) disable iff (reset)
      $onehot0(hit))
      else $error("both buttons reported a take");

   a_rsp_loaded: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("result lost on transfer");

endmodule

/* rtl/bslc_button.sv */
// One button: state code register and its next-state logic
`timescale 1ns / 1ps
module bslc_button (
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  logic [1:0]       opcode,
   input  logic             selected,
   input  logic             released,
   input  bslc_pkg::cfg_type cfg,
   output logic             hit
);
   import bslc_pkg::*;

   logic [7:0] code_ff;
   logic [7:0] code_in;
   logic [7:0] code_inc;
   logic [7:0] want;

   assign code_inc = code_ff + 8'd1;
   assign want     = (opcode == OP_TAKE_SHORT) ? CODE_SHORT : CODE_LONG;
   assign hit      = selected && (code_ff == want) &&
                     ((opcode == OP_TAKE_SHORT) || (opcode == OP_TAKE_LONG));

   always_comb begin
      code_in = code_ff;
      case (opcode)
         OP_TICK: begin
            if (code_ff < CODE_HOLDOFF) begin
               if (!released) begin
                  code_in = (code_inc >= {1'b0, cfg.long_ticks}) ? CODE_LONG : code_inc;
               end else begin
                  code_in = (code_ff >= {2'b00, cfg.min_ticks}) ? CODE_SHORT : CODE_IDLE;
               end
            end else if (code_ff < CODE_HOLD_END && released) begin
               // count released ticks of the hold-off, then fall back to idle
               code_in = (code_inc >= CODE_HOLDOFF + {2'b00, cfg.holdoff_ticks}) ?
                         CODE_IDLE : code_inc;
            end
         end
         OP_TAKE_SHORT, OP_TAKE_LONG: begin
            if (hit) begin
               code_in = CODE_TAKEN;
            end
         end
         OP_CLEAR: begin
            if (released && code_ff > CODE_EVENTS) begin
               code_in = CODE_HOLDOFF;
            end
         end
         default: code_in = code_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         code_ff <= CODE_IDLE;
      end else if (advance) begin
         code_ff <= code_in;
      end
   end

   // Codes stay inside the count ranges or the three event codes
   a_code_range: assert property (@(posedge clock) disable iff (reset)
      code_ff < CODE_HOLD_END || code_ff == CODE_SHORT || code_ff == CODE_LONG ||
      code_ff == CODE_TAKEN)
      else $error("button code out of range");

   a_take_marks: assert property (@(posedge clock) disable iff (reset)
      advance && hit |=> code_ff == CODE_TAKEN)
      else $error("taken event not marked");

   a_hold_idle: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(code_ff))
      else $error("button code changed without a transfer");

endmodule

/* dv/tb_top.sv */
// Testbench for the two-button short/long press classifier: random and directed pin samples
`timescale 1ns / 1ps
module tb_top;
   import bslc_pkg::*;

   localparam int CYCLE_LIMIT  = 400000;
   localparam int DRAIN_CYCLES = 6;
   localparam int PRINT_CAP    = 200;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_valid = 1'b0;
   logic                  req_stall;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   button_short_long_press_classifier_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Predictor state: threshold registers and the per-button state codes
   logic [5:0] min_ticks_reg  = MIN_PRESS_RESET;
   logic [6:0] long_ticks_reg = LONG_PRESS_RESET;
   logic [5:0] holdoff_reg    = HOLDOFF_RESET;
   logic [7:0] btn_code [2]   = '{CODE_IDLE, CODE_IDLE};

   req_type sample_queue [$];
   rsp_type predicted_results [$];

   int  gap_left     = 0;
   int  stall_left   = 0;
   bit  idle_on      = 1'b1;
   int  queued_count = 0;
   int  result_count = 0;
   int  mismatches   = 0;
   int  cycles       = 0;

   function automatic int eff_long();
      return (long_ticks_reg > LONG_PRESS_MAX) ? int'(LONG_PRESS_MAX) : int'(long_ticks_reg);
   endfunction

   function automatic int eff_min();
      return (min_ticks_reg == 0) ? 1 : int'(min_ticks_reg);
   endfunction

   function automatic int eff_holdoff();
      return (holdoff_reg > HOLDOFF_MAX) ? int'(HOLDOFF_MAX) : int'(holdoff_reg);
   endfunction

   function automatic logic [7:0] code_after_tick(logic [7:0] code, logic released);
      int c;
      c = int'(code);
      if (c < int'(CODE_HOLDOFF)) begin
         if (!released) begin
            c++;
            if (c >= eff_long())
               c = int'(CODE_LONG);
         end else begin
            c = (c >= eff_min()) ? int'(CODE_SHORT) : int'(CODE_IDLE);
         end
      end else if (c < int'(CODE_HOLD_END) && released) begin
         c++;
         if (c >= int'(CODE_HOLDOFF) + eff_holdoff())
            c = int'(CODE_IDLE);
      end
      return c[7:0];
   endfunction

   function automatic rsp_type classify_sample(req_type s);
      rsp_type    r;
      logic [1:0] rel;
      logic [7:0] want;
      int         n;
      rel[0] = s.up_released;
      rel[1] = s.down_released;
      r.event_taken = 1'b0;
      case (s.opcode)
         OP_TICK: begin
            btn_code[0] = code_after_tick(btn_code[0], rel[0]);
            btn_code[1] = code_after_tick(btn_code[1], rel[1]);
         end
         OP_TAKE_SHORT, OP_TAKE_LONG: begin
            want = (s.opcode == OP_TAKE_SHORT) ? CODE_SHORT : CODE_LONG;
            if (btn_code[s.button] == want) begin
               btn_code[s.button] = CODE_TAKEN;
               r.event_taken = 1'b1;
            end
         end
         default: begin
            for (n = 0; n < 2; n++)
               if (rel[n] && btn_code[n] > CODE_EVENTS)
                  btn_code[n] = CODE_HOLDOFF;
         end
      endcase
      r.held = ~rel[s.button];
      return r;
   endfunction

   task automatic report_mismatch(string msg);
      if (mismatches < PRINT_CAP)
         $display("mismatch at result %0d: %s", result_count, msg);
      mismatches++;
   endtask

   // Driver: present queued samples, predict each one on its transfer
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall)
            predicted_results.push_back(classify_sample(req_data));
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (sample_queue.size() != 0) begin
               req_data  <= sample_queue.pop_front();
               req_valid <= 1'b1;
               if (idle_on && $urandom_range(0, 7) == 0)
                  gap_left = $urandom_range(1, 6);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: check each result transfer against the oldest prediction, drive stall bursts
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (predicted_results.size() == 0) begin
               report_mismatch("result with nothing pending");
            end else begin
               rsp_type want;
               want = predicted_results.pop_front();
               if (rsp_data.event_taken !== want.event_taken)
                  report_mismatch($sformatf("event_taken %b, want %b",
                                            rsp_data.event_taken, want.event_taken));
               if (rsp_data.held !== want.held)
                  report_mismatch($sformatf("held %b, want %b", rsp_data.held, want.held));
            end
            result_count++;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
            if (idle_on && $urandom_range(0, 9) == 0)
               stall_left = $urandom_range(1, 6);
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("FAILED: results differ");
         $finish;
      end
   end

   task automatic push_sample(logic [1:0] op, logic sel, logic up_rel, logic dn_rel);
      req_type s;
      s.opcode        = op;
      s.button        = sel;
      s.up_released   = up_rel;
      s.down_released = dn_rel;
      sample_queue.push_back(s);
      queued_count++;
   endtask

   // Pin levels for a sample centered on button b
   task automatic push_for(logic [1:0] op, logic sel, logic b, logic b_rel, logic other_rel);
      push_sample(op, sel, b ? other_rel : b_rel, b ? b_rel : other_rel);
   endtask

   task automatic write_csr(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_MIN_PRESS:  min_ticks_reg  = val[5:0];
         CSR_LONG_PRESS: long_ticks_reg = val[6:0];
         CSR_HOLDOFF:    holdoff_reg    = val[5:0];
         default: ;
      endcase
   endtask

   task automatic set_thresholds(int mn, int lng, int ho);
      write_csr(CSR_MIN_PRESS, mn[CSR_DATA_W-1:0]);
      write_csr(CSR_LONG_PRESS, lng[CSR_DATA_W-1:0]);
      write_csr(CSR_HOLDOFF, ho[CSR_DATA_W-1:0]);
   endtask

   task automatic wait_drained();
      do @(posedge clock);
      while (sample_queue.size() != 0 || req_valid || predicted_results.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Mostly whole press/release/take/clear/hold-off sequences, some raw noise
   task automatic gen_press_stream(int count, bit quiet);
      int   stop_at;
      int   len;
      int   n;
      logic b;
      logic other_rel;
      stop_at = queued_count + count;
      while (queued_count < stop_at) begin
         idle_on = quiet ? 1'b0 : ($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 4) == 0) begin
            push_sample(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                        1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
         end else begin
            b = 1'($urandom_range(0, 1));
            other_rel = ($urandom_range(0, 3) != 0);
            len = $urandom_range(0, eff_long() + 2);
            for (n = 0; n < len; n++) begin
               if ($urandom_range(0, 7) == 0)
                  push_for(2'($urandom_range(1, 2)), 1'($urandom_range(0, 1)), b, 1'b0,
                           other_rel);
               push_for(OP_TICK, 1'($urandom_range(0, 1)), b, 1'b0, other_rel);
            end
            push_for(OP_TICK, b, b, 1'b1, other_rel);
            repeat ($urandom_range(0, 2))
               push_for(2'($urandom_range(1, 2)), ($urandom_range(0, 3) != 0) ? b : ~b,
                        b, 1'b1, other_rel);
            if ($urandom_range(0, 3) != 0)
               push_for(OP_CLEAR, 1'($urandom_range(0, 1)), b, ($urandom_range(0, 7) != 0),
                        ($urandom_range(0, 1) != 0));
            len = $urandom_range(0, eff_holdoff() + 2);
            for (n = 0; n < len; n++)
               push_for(OP_TICK, 1'($urandom_range(0, 1)), b, ($urandom_range(0, 9) != 0),
                        other_rel);
         end
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Reset thresholds: counting, short press, take, clear, pressed during hold-off
      push_sample(OP_TICK,       1'b0, 1'b1, 1'b1);
      push_sample(OP_TICK,       1'b0, 1'b0, 1'b1);
      push_sample(OP_TICK,       1'b0, 1'b0, 1'b1);
      push_sample(OP_TICK,       1'b1, 1'b1, 1'b1);
      push_sample(OP_TAKE_LONG,  1'b0, 1'b1, 1'b1);
      push_sample(OP_TAKE_SHORT, 1'b0, 1'b1, 1'b1);
      push_sample(OP_TAKE_SHORT, 1'b0, 1'b1, 1'b1);
      push_sample(OP_TICK,       1'b0, 1'b1, 1'b1);
      push_sample(OP_CLEAR,      1'b1, 1'b1, 1'b0);
      push_sample(OP_TICK,       1'b0, 1'b0, 1'b0);
      push_sample(OP_TICK,       1'b1, 1'b1, 1'b1);
      push_sample(OP_TAKE_SHORT, 1'b1, 1'b1, 1'b1);
      wait_drained();

      // Zero minimum, long threshold of one, zero hold-off
      set_thresholds(0, 1, 0);
      push_sample(OP_TICK,       1'b0, 1'b1, 1'b1);
      push_sample(OP_TAKE_SHORT, 1'b0, 1'b1, 1'b1);
      push_sample(OP_TICK,       1'b1, 1'b0, 1'b0);
      push_sample(OP_TAKE_LONG,  1'b1, 1'b0, 1'b0);
      push_sample(OP_TAKE_LONG,  1'b0, 1'b0, 1'b0);
      push_sample(OP_CLEAR,      1'b0, 1'b0, 1'b0);
      push_sample(OP_CLEAR,      1'b1, 1'b1, 1'b0);
      push_sample(OP_TICK,       1'b0, 1'b1, 1'b1);
      push_sample(OP_CLEAR,      1'b1, 1'b1, 1'b1);
      push_sample(OP_TAKE_SHORT, 1'b1, 1'b1, 1'b1);
      push_sample(OP_TICK,       1'b1, 1'b1, 1'b1);
      gen_press_stream(150, 1'b0);
      wait_drained();

      set_thresholds(int'(MIN_PRESS_RESET), int'(LONG_PRESS_RESET), int'(HOLDOFF_RESET));
      gen_press_stream(150, 1'b0);
      wait_drained();

      set_thresholds(1, 2, 1);
      gen_press_stream(300, 1'b0);
      wait_drained();

      set_thresholds(59, 99, 49);
      gen_press_stream(300, 1'b0);
      wait_drained();

      // Out-of-range thresholds get limited; the unused index is ignored
      set_thresholds(127, 127, 127);
      write_csr(CSR_UNUSED, CSR_DATA_W'($urandom_range(0, 127)));
      gen_press_stream(250, 1'b0);
      wait_drained();

      set_thresholds($urandom_range(1, 6), $urandom_range(3, 25), $urandom_range(1, 12));
      gen_press_stream(200, 1'b0);
      wait_drained();

      // Final stretch runs back to back
      set_thresholds($urandom_range(1, 4), $urandom_range(2, 12), $urandom_range(1, 6));
      gen_press_stream(250, 1'b1);
      wait_drained();

      if (predicted_results.size() != 0)
         report_mismatch($sformatf("%0d results never arrived", predicted_results.size()));
      if (mismatches == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule
